// File: src/rbch_pkg.sv
// Shared types, constants and codes for the ray versus box closest-hit block.
package rbch_pkg;

   localparam int MaxBoxes  = 1024;
   localparam int CountW    = $clog2(MaxBoxes);
   localparam int IdxW      = 10;
   localparam int CoordW    = 32;
   localparam int HalfW     = 31;
   localparam int DistW     = 31;
   localparam int NumW      = CoordW + 2;            // (bound - origin), signed
   localparam int FracW     = 16;                    // Q16.16 scale shift
   localparam int DvdW      = NumW - 1 + FracW;      // dividend magnitude
   localparam int QuoW      = DvdW + 1;              // signed quotient
   localparam int CsrIdxW   = 3;
   localparam int FifoDepth = 2;
   localparam int FifoPtrW  = $clog2(FifoDepth);

   typedef enum logic [CsrIdxW-1:0] {
      CSR_ORIGIN_X     = 3'd0,
      CSR_ORIGIN_Y     = 3'd1,
      CSR_ORIGIN_Z     = 3'd2,
      CSR_DIR_X        = 3'd3,
      CSR_DIR_Y        = 3'd4,
      CSR_DIR_Z        = 3'd5,
      CSR_MAX_DISTANCE = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic signed [CoordW-1:0] center_x;
      logic signed [CoordW-1:0] center_y;
      logic signed [CoordW-1:0] center_z;
      logic [HalfW-1:0]         half_x;
      logic [HalfW-1:0]         half_y;
      logic [HalfW-1:0]         half_z;
      logic                     eligible;
      logic                     last_box;
   } req_payload_type;

   typedef struct packed {
      logic            hit;
      logic [IdxW-1:0] hit_index;
      logic [DistW-1:0] hit_distance;
   } rsp_payload_type;

   typedef struct packed {
      logic [2:0][CoordW-1:0] origin;
      logic [2:0][CoordW-1:0] dir;
      logic [DistW-1:0]       max_distance;
   } cfg_type;

   // One classified box waiting for the slab sequencer.
   typedef struct packed {
      logic [2:0][NumW-1:0] num_lo;
      logic [2:0][NumW-1:0] num_hi;
      logic [2:0]           in_slab;
      logic                 eligible;
      logic                 last_box;
   } job_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_AXIS,
      ST_DIV_LO,
      ST_DIV_HI,
      ST_CLIP,
      ST_CHECK,
      ST_FINISH
   } back_state_type;

endpackage

// File: src/rbch_front.sv
// Input stage: take a box item, form slab bounds relative to the ray origin.
module rbch_front
   import rbch_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  cfg_type         cfg,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            push,
   output job_type         push_job,
   input  logic            fifo_full
);

   logic            stage_valid_ff, stage_valid_in;
   req_payload_type stage_ff;
   logic            accept;

   logic [2:0][CoordW-1:0] center;
   logic [2:0][HalfW-1:0]  half;

   assign req_stall = stage_valid_ff & fifo_full;
   assign accept    = req_valid & ~req_stall;
   assign push      = stage_valid_ff & ~fifo_full;

   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (push) stage_valid_in = 1'b0;
      if (accept) stage_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) stage_ff <= req_payload;
   end

   assign center = {stage_ff.center_z, stage_ff.center_y, stage_ff.center_x};
   assign half   = {stage_ff.half_z, stage_ff.half_y, stage_ff.half_x};

   always_comb begin
      logic [CoordW:0]   lo, hi;
      logic [NumW-1:0]   nlo, nhi, org;
      push_job = '0;
      for (int a = 0; a < 3; a++) begin
         lo  = {center[a][CoordW-1], center[a]} - {2'b00, half[a]};
         hi  = {center[a][CoordW-1], center[a]} + {2'b00, half[a]};
         org = {{2{cfg.origin[a][CoordW-1]}}, cfg.origin[a]};
         nlo = {lo[CoordW], lo} - org;
         nhi = {hi[CoordW], hi} - org;
         push_job.num_lo[a]  = nlo;
         push_job.num_hi[a]  = nhi;
         // origin inside the slab: lo - o <= 0 and hi - o >= 0
         push_job.in_slab[a] = (nlo[NumW-1] | (nlo == '0)) & ~nhi[NumW-1];
      end
      push_job.eligible = stage_ff.eligible;
      push_job.last_box = stage_ff.last_box;
   end

endmodule

// File: src/rbch_fifo.sv
// Short queue of classified box items between front and back.
module rbch_fifo
   import rbch_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output logic    head_valid,
   output job_type head_job
);

   job_type             mem [FifoDepth];
   logic [FifoPtrW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [FifoPtrW:0]   fill_ff, fill_in;

   assign full       = (fill_ff == (FifoPtrW + 1)'(FifoDepth));
   assign head_valid = (fill_ff != '0);
   assign head_job   = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff + (FifoPtrW + 1)'(push) - (FifoPtrW + 1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem[wr_ptr_ff] <= push_job;
   end

endmodule

// File: src/rbch_div.sv
// Radix-2 restoring divider: ((num * 65536) / den), truncated toward zero.
module rbch_div
   import rbch_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [NumW-1:0]   num,
   input  logic [CoordW-1:0] den,
   output logic              done,
   output logic [QuoW-1:0]   quo
);

   localparam int CntW = $clog2(DvdW + 1);

   logic              busy_ff, busy_in, done_ff, done_in;
   logic [CntW-1:0]   cnt_ff, cnt_in;
   logic [DvdW-1:0]   q_ff, q_in;
   logic [CoordW-1:0] rem_ff, rem_in, dmag_ff, dmag_in;
   logic              neg_ff, neg_in;

   always_comb begin
      logic [NumW-1:0]   nmag;
      logic [CoordW:0]   trial;
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      q_in    = q_ff;
      rem_in  = rem_ff;
      dmag_in = dmag_ff;
      neg_in  = neg_ff;
      nmag    = num[NumW-1] ? -num : num;
      trial   = {rem_ff, q_ff[DvdW-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CntW'(DvdW);
         q_in    = {nmag[NumW-2:0], {FracW{1'b0}}};
         rem_in  = '0;
         dmag_in = den[CoordW-1] ? -den : den;
         neg_in  = num[NumW-1] ^ den[CoordW-1];
      end else if (busy_ff) begin
         if (trial >= {1'b0, dmag_ff}) begin
            rem_in = CoordW'(trial - {1'b0, dmag_ff});
            q_in   = {q_ff[DvdW-2:0], 1'b1};
         end else begin
            rem_in = trial[CoordW-1:0];
            q_in   = {q_ff[DvdW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      q_ff    <= q_in;
      rem_ff  <= rem_in;
      dmag_ff <= dmag_in;
      neg_ff  <= neg_in;
   end

   assign done = done_ff;
   assign quo  = neg_ff ? -{1'b0, q_ff} : {1'b0, q_ff};

endmodule

// File: src/rbch_back.sv
// Slab sequencer, closest-hit tracking and result register.
module rbch_back
   import rbch_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  logic              job_valid,
   input  job_type           job,
   output logic              pop,
   output logic              div_start,
   output logic [NumW-1:0]   div_num,
   output logic [CoordW-1:0] div_den,
   input  logic              div_done,
   input  logic [QuoW-1:0]   div_quo,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsp_payload_type   rsp_payload
);

   back_state_type state_ff, state_in;

   logic [1:0]              axis_ff, axis_in;
   logic signed [QuoW-1:0]  tmin_ff, tmin_in, tmax_ff, tmax_in;
   logic signed [QuoW-1:0]  t1_ff, t1_in, t2_ff, t2_in;
   logic                    hit_ff, hit_in;
   logic [DistW-1:0]        best_ff, best_in;
   logic [CountW-1:0]       idx_ff, idx_in, count_ff, count_in;
   logic                    found_ff, found_in, active_ff, active_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_payload_type         rsp_ff, rsp_in;

   logic [CoordW-1:0] dir_cur;
   logic              dir_zero, last_axis, out_free, can_finish, slab_ok;

   assign dir_cur    = cfg.dir[axis_ff];
   assign dir_zero   = (dir_cur == '0);
   assign last_axis  = (axis_ff == 2'd2);
   assign out_free   = ~rsp_valid_ff | ~rsp_stall;
   assign can_finish = ~job.last_box | out_free;
   assign slab_ok    = (tmin_ff <= tmax_ff);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (job_valid) state_in = job.eligible ? ST_AXIS : ST_FINISH;
         ST_AXIS: begin
            if (!dir_zero) state_in = ST_DIV_LO;
            else if (!job.in_slab[axis_ff] || last_axis) state_in = ST_FINISH;
         end
         ST_DIV_LO: if (div_done) state_in = ST_DIV_HI;
         ST_DIV_HI: if (div_done) state_in = ST_CLIP;
         ST_CLIP:   state_in = ST_CHECK;
         ST_CHECK:  state_in = (!slab_ok || last_axis) ? ST_FINISH : ST_AXIS;
         ST_FINISH: if (can_finish) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      logic                   nfound;
      logic [DistW-1:0]       nbest;
      logic [CountW-1:0]      nidx;
      logic signed [QuoW-1:0] near_t, far_t;
      axis_in      = axis_ff;
      tmin_in      = tmin_ff;
      tmax_in      = tmax_ff;
      t1_in        = t1_ff;
      t2_in        = t2_ff;
      hit_in       = hit_ff;
      best_in      = best_ff;
      idx_in       = idx_ff;
      count_in     = count_ff;
      found_in     = found_ff;
      active_in    = active_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      pop          = 1'b0;
      div_start    = 1'b0;
      div_num      = job.num_lo[axis_ff];
      div_den      = dir_cur;
      nfound       = found_ff | hit_ff;
      nbest        = hit_ff ? tmin_ff[DistW-1:0] : best_ff;
      nidx         = hit_ff ? count_ff : idx_ff;
      near_t       = (t1_ff > t2_ff) ? t2_ff : t1_ff;
      far_t        = (t1_ff > t2_ff) ? t1_ff : t2_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               axis_in = '0;
               hit_in  = 1'b0;
               tmin_in = '0;
               tmax_in = QuoW'({1'b0, active_ff ? best_ff : cfg.max_distance});
               if (!active_ff) begin
                  best_in   = cfg.max_distance;
                  idx_in    = '0;
                  found_in  = 1'b0;
                  count_in  = '0;
                  active_in = 1'b1;
               end
            end
         end
         ST_AXIS: begin
            if (!dir_zero) begin
               div_start = 1'b1;
            end else if (job.in_slab[axis_ff]) begin
               if (last_axis) hit_in = 1'b1;
               else axis_in = axis_ff + 2'd1;
            end
         end
         ST_DIV_LO: begin
            if (div_done) begin
               t1_in     = div_quo;
               div_start = 1'b1;
               div_num   = job.num_hi[axis_ff];
            end
         end
         ST_DIV_HI: begin
            if (div_done) t2_in = div_quo;
         end
         ST_CLIP: begin
            if (near_t > tmin_ff) tmin_in = near_t;
            if (far_t < tmax_ff) tmax_in = far_t;
         end
         ST_CHECK: begin
            if (slab_ok) begin
               if (last_axis) hit_in = 1'b1;
               else axis_in = axis_ff + 2'd1;
            end
         end
         ST_FINISH: begin
            if (can_finish) begin
               pop      = 1'b1;
               found_in = nfound;
               best_in  = nbest;
               idx_in   = nidx;
               count_in = (count_ff == CountW'(MaxBoxes - 1)) ? '0 : count_ff + 1'b1;
               if (job.last_box) begin
                  rsp_valid_in         = 1'b1;
                  rsp_in.hit           = nfound;
                  rsp_in.hit_index     = IdxW'(nidx);
                  rsp_in.hit_distance  = nbest;
                  active_in            = 1'b0;
                  found_in             = 1'b0;
                  idx_in               = '0;
                  count_in             = '0;
                  best_in              = cfg.max_distance;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         active_ff    <= 1'b0;
         found_ff     <= 1'b0;
         idx_ff       <= '0;
         count_ff     <= '0;
         hit_ff       <= 1'b0;
         axis_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         found_ff     <= found_in;
         idx_ff       <= idx_in;
         count_ff     <= count_in;
         hit_ff       <= hit_in;
         axis_ff      <= axis_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tmin_ff <= tmin_in;
      tmax_ff <= tmax_in;
      t1_ff   <= t1_in;
      t2_ff   <= t2_in;
      best_ff <= best_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// File: src/ray_box_closest_hit.sv
// Top level: ray versus axis-aligned box closest-hit search, Q16.16.
//
//   channel  | direction | handshake          | carries
//   ---------+-----------+--------------------+-----------------------------------
//   req_     | in        | req_valid/stall    | box centre, half extent, flags
//   rsp_     | out       | rsp_valid/stall    | hit, hit index, hit distance
//   csr_     | in        | csr_valid/ready    | register index and write data
//
// In the back end an item passes a pick-up step and a finish step, one axis step per
// parallel axis tested, and per non-parallel axis tested two quotients from the single
// shared bit-per-cycle divider plus the axis, clip and check steps. The divider sets
// the rate.
// Reset is synchronous and active high; it restores the register defaults.
// A two-item queue lets the front keep taking items while the back end works;
// a stalled result waits in the output register and only the last box waits on it.
module ray_box_closest_hit
   import rbch_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  req_payload_type     req_payload,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output rsp_payload_type     rsp_payload,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CoordW-1:0]   csr_wdata
);

   cfg_type cfg_ff, cfg_in;

   logic              push, fifo_full, pop, head_valid;
   job_type           push_job, head_job;
   logic              div_start, div_done;
   logic [NumW-1:0]   div_num;
   logic [CoordW-1:0] div_den;
   logic [QuoW-1:0]   div_quo;

   // Always ready; write only while no item is in flight.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_ORIGIN_X:     cfg_in.origin[0]    = csr_wdata;
            CSR_ORIGIN_Y:     cfg_in.origin[1]    = csr_wdata;
            CSR_ORIGIN_Z:     cfg_in.origin[2]    = csr_wdata;
            CSR_DIR_X:        cfg_in.dir[0]       = csr_wdata;
            CSR_DIR_Y:        cfg_in.dir[1]       = csr_wdata;
            CSR_DIR_Z:        cfg_in.dir[2]       = csr_wdata;
            CSR_MAX_DISTANCE: cfg_in.max_distance = csr_wdata[DistW-1:0];
            default: ;   // drop writes to unused indexes
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.origin       <= '0;
         cfg_ff.dir          <= {CoordW'(32'h0001_0000), {CoordW{1'b0}}, {CoordW{1'b0}}};
         cfg_ff.max_distance <= DistW'(32'h0004_0000);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front: register the box and form bounds relative to the origin.
   rbch_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .push        (push),
      .push_job    (push_job),
      .fifo_full   (fifo_full)
   );

   rbch_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .full       (fifo_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   // Shared divider for all slab distances.
   rbch_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   // Back: slab test, closest-hit update, result on the last box.
   rbch_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .job_valid   (head_valid),
      .job         (head_job),
      .pop         (pop),
      .div_start   (div_start),
      .div_num     (div_num),
      .div_den     (div_den),
      .div_done    (div_done),
      .div_quo     (div_quo),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

// File: tb/sv/rbch_checker.sv
// Checker for the ray versus box closest-hit block: predicts every report and compares it.
module rbch_checker
   import rbch_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_stall,
   input  req_payload_type     req_payload,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  rsp_payload_type     rsp_payload,
   input  logic                csr_valid,
   input  logic                csr_ready,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CoordW-1:0]   csr_wdata,
   output int                  fail_count,
   output int                  reports_due
);

   logic signed [CoordW-1:0] ray_org [3];
   logic signed [CoordW-1:0] ray_dir [3];
   logic [DistW-1:0]         far_limit;

   longint          nearest_dist;
   logic [IdxW-1:0] nearest_idx;
   bit              any_hit;
   int unsigned     box_pos;
   bit              in_query;
   int              mismatches;
   rsp_payload_type hit_reports_q[$];

   // clip [tmin, tmax] against one slab; a zero direction needs the origin inside
   function automatic bit clip_slab(longint o, longint d, longint lo, longint hi,
                                    inout longint tmin, inout longint tmax);
      longint t_near, t_far, t_swap;
      if (d == 0) return !(o < lo || o > hi);
      t_near = ((lo - o) * 65536) / d;
      t_far  = ((hi - o) * 65536) / d;
      if (t_near > t_far) begin
         t_swap = t_near; t_near = t_far; t_far = t_swap;
      end
      if (t_near > tmin) tmin = t_near;
      if (t_far < tmax) tmax = t_far;
      return tmin <= tmax;
   endfunction

   task automatic trace_box(input req_payload_type b);
      longint tmin, tmax, c, h;
      bit hit_box;
      rsp_payload_type rep;
      tmin = 0;
      hit_box = 1'b1;
      if (!in_query) begin
         nearest_dist = far_limit;
         nearest_idx  = '0;
         any_hit      = 1'b0;
         box_pos      = 0;
         in_query     = 1'b1;
      end
      if (b.eligible) begin
         tmax = nearest_dist;
         for (int a = 0; a < 3 && hit_box; a++) begin
            c = (a == 0) ? b.center_x : (a == 1) ? b.center_y : b.center_z;
            h = (a == 0) ? longint'(b.half_x) : (a == 1) ? longint'(b.half_y)
                                                         : longint'(b.half_z);
            hit_box = clip_slab(ray_org[a], ray_dir[a], c - h, c + h, tmin, tmax);
         end
         if (hit_box) begin
            nearest_dist = tmin;
            nearest_idx  = box_pos[IdxW-1:0];
            any_hit      = 1'b1;
         end
      end
      box_pos = (box_pos + 1 >= MaxBoxes) ? 0 : box_pos + 1;
      if (b.last_box) begin
         rep.hit          = any_hit;
         rep.hit_index    = any_hit ? nearest_idx : '0;
         rep.hit_distance = nearest_dist[DistW-1:0];
         hit_reports_q.push_back(rep);
         in_query = 1'b0;
      end
   endtask

   task automatic check_report(input rsp_payload_type got);
      rsp_payload_type want;
      if (hit_reports_q.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("unexpected report: hit %0d index %0d distance %0h",
                     got.hit, got.hit_index, got.hit_distance);
         return;
      end
      want = hit_reports_q.pop_front();
      if (got.hit !== want.hit || got.hit_index !== want.hit_index ||
          got.hit_distance !== want.hit_distance) begin
         mismatches++;
         if (mismatches <= 10)
            $display("report mismatch: expected hit %0d index %0d distance %0h, got hit %0d index %0d distance %0h",
                     want.hit, want.hit_index, want.hit_distance,
                     got.hit, got.hit_index, got.hit_distance);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         ray_org[0] = '0; ray_org[1] = '0; ray_org[2] = '0;
         ray_dir[0] = '0; ray_dir[1] = '0; ray_dir[2] = 32'sd65536;
         far_limit  = 31'd262144;
         in_query   = 1'b0;
         any_hit    = 1'b0;
         box_pos    = 0;
         mismatches = 0;
         hit_reports_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ORIGIN_X:     ray_org[0] = csr_wdata;
               CSR_ORIGIN_Y:     ray_org[1] = csr_wdata;
               CSR_ORIGIN_Z:     ray_org[2] = csr_wdata;
               CSR_DIR_X:        ray_dir[0] = csr_wdata;
               CSR_DIR_Y:        ray_dir[1] = csr_wdata;
               CSR_DIR_Z:        ray_dir[2] = csr_wdata;
               CSR_MAX_DISTANCE: far_limit  = csr_wdata[DistW-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) check_report(rsp_payload);
         if (req_valid && !req_stall) trace_box(req_payload);
      end
      fail_count  <= mismatches;
      reports_due <= hit_reports_q.size();
   end

endmodule

// File: tb/sv/tb_top.sv
// Top of the testbench: clock, reset, box stimulus, register writes and the verdict.
module tb_top;
   import rbch_pkg::*;

   localparam int          RunLimit   = 3000000;
   localparam int          SettleWait = 400;   // longest item in the back end, with margin
   localparam logic [CsrIdxW-1:0] CsrSpare = 3'd7;   // no register behind this index
   localparam int          Q1         = 65536;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   req_payload_type    req_payload = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   rsp_payload_type    rsp_payload;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [CsrIdxW-1:0] csr_index = '0;
   logic [CoordW-1:0]  csr_wdata = '0;
   int                 fail_count;
   int                 reports_due;

   // pacing knobs, percent per cycle
   int sender_idle_pct = 0;
   int recv_stall_pct  = 0;
   int hold_asked      = 0;
   int hold_served     = 0;
   int hold_left       = 0;
   int cycle_count     = 0;

   // stimulus copy of the ray, used only to aim boxes
   longint aim_org [3];
   longint aim_dir [3];
   longint aim_far;

   always #5 clock = ~clock;

   ray_box_closest_hit dut (
      .clock, .reset, .req_valid, .req_stall, .req_payload,
      .rsp_valid, .rsp_stall, .rsp_payload,
      .csr_valid, .csr_ready, .csr_index, .csr_wdata
   );

   rbch_checker u_checker (
      .clock, .reset, .req_valid, .req_stall, .req_payload,
      .rsp_valid, .rsp_stall, .rsp_payload,
      .csr_valid, .csr_ready, .csr_index, .csr_wdata,
      .fail_count, .reports_due
   );

   // watchdog: end the run if the block hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > RunLimit) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // receiver: random stalls, or a long hold-off when one is asked for
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (hold_served != hold_asked) begin
         hold_served = hold_asked;
         hold_left = 3000;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
   end

   // offer one item; keep valid high if the next follows without a gap
   task automatic send_box(input req_payload_type b);
      if ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < sender_idle_pct);
      end
      req_valid   <= 1'b1;
      req_payload <= b;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic idle_sender();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_reg(input logic [CsrIdxW-1:0] idx, input logic [CoordW-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // drain every report, then allow the back end to finish an item with none
   task automatic drain();
      while (reports_due != 0) @(posedge clock);
      repeat (SettleWait) @(posedge clock);
   endtask

   task automatic set_ray(input longint o[3], input longint d[3], input longint far_d);
      write_reg(CSR_ORIGIN_X, o[0][31:0]);
      write_reg(CSR_ORIGIN_Y, o[1][31:0]);
      write_reg(CSR_ORIGIN_Z, o[2][31:0]);
      write_reg(CSR_DIR_X, d[0][31:0]);
      write_reg(CSR_DIR_Y, d[1][31:0]);
      write_reg(CSR_DIR_Z, d[2][31:0]);
      write_reg(CSR_MAX_DISTANCE, far_d[31:0]);
      aim_org = o;
      aim_dir = d;
      aim_far = far_d;
   endtask

   function automatic req_payload_type mk_box(longint cx, longint cy, longint cz,
                                              longint hx, longint hy, longint hz,
                                              bit el, bit last);
      req_payload_type b;
      b.center_x = cx[31:0];
      b.center_y = cy[31:0];
      b.center_z = cz[31:0];
      b.half_x   = hx[30:0];
      b.half_y   = hy[30:0];
      b.half_z   = hz[30:0];
      b.eligible = el;
      b.last_box = last;
      return b;
   endfunction

   // box placed on the ray at a random distance, with a little jitter
   function automatic req_payload_type aimed_box(bit last);
      longint t, c[3], h[3];
      t = $urandom_range(0, 2 * int'(aim_far > 32'h3fff_ffff ? 32'h3fff_ffff : aim_far));
      for (int a = 0; a < 3; a++) begin
         c[a] = aim_org[a] + ((aim_dir[a] * t) >>> 16)
                + longint'($urandom_range(0, 'h8000)) - 'h4000;
         h[a] = ($urandom_range(0, 7) == 0) ? longint'($urandom & 32'h7fff_ffff)
                                            : longint'($urandom_range(0, 'h30000));
      end
      return mk_box(c[0], c[1], c[2], h[0], h[1], h[2], $urandom_range(0, 5) != 0, last);
   endfunction

   function automatic req_payload_type noise_box(bit last);
      return mk_box(longint'(signed'($urandom)), longint'(signed'($urandom)),
                    longint'(signed'($urandom)), $urandom & 32'h7fff_ffff,
                    $urandom & 32'h7fff_ffff, $urandom & 32'h7fff_ffff,
                    $urandom_range(0, 1), last);
   endfunction

   function automatic longint rand_dir();
      case ($urandom_range(0, 5))
         0, 1:    return 0;                              // parallel: keeps items quick
         2:       return longint'(signed'($urandom));
         default: return longint'($urandom_range(0, 2 * Q1)) - Q1;
      endcase
   endfunction

   initial begin
      longint o[3], d[3];
      int sent, qlen;
      bit tail;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part, reset ray: origin 0, direction +z, reach 4.0
      aim_org = '{0, 0, 0};
      aim_dir = '{0, 0, Q1};
      aim_far = 4 * Q1;
      // plain hit, then a tie: the later of two identical boxes must win
      send_box(mk_box(0, 0, 2 * Q1, Q1 / 2, Q1 / 2, Q1 / 2, 1, 0));
      send_box(mk_box(0, 0, 2 * Q1, Q1 / 2, Q1 / 2, Q1 / 2, 1, 1));
      // parallel axes: origin outside the x slab misses, ineligible box is skipped
      send_box(mk_box(5 * Q1, 0, Q1, Q1, Q1, Q1, 1, 0));
      send_box(mk_box(0, 0, Q1, Q1, Q1, Q1, 0, 1));
      // field extremes
      send_box(mk_box(32'sh7fff_ffff, -32'sh8000_0000, 32'sh7fff_ffff,
                      31'h7fff_ffff, 0, 31'h7fff_ffff, 1, 0));
      send_box(mk_box(-32'sh8000_0000, 32'sh7fff_ffff, -32'sh8000_0000,
                      0, 31'h7fff_ffff, 0, 1, 1));
      send_box(mk_box(0, 0, -32'sh8000_0000, 31'h7fff_ffff, 31'h7fff_ffff,
                      31'h7fff_ffff, 1, 1));
      // box behind the origin and one beyond reach: no hit reports max_distance
      send_box(mk_box(0, 0, -3 * Q1, Q1, Q1, Q1, 1, 0));
      send_box(mk_box(0, 0, 9 * Q1, Q1, Q1, Q1, 1, 1));
      idle_sender();
      drain();
      // write to an index with no register behind it: must change nothing
      write_reg(CsrSpare, 32'hffff_ffff);
      send_box(mk_box(0, 0, 3 * Q1, Q1 / 4, Q1 / 4, Q1 / 4, 1, 1));
      idle_sender();
      drain();
      // zero reach: only a box around the origin can hit, at distance zero
      set_ray('{Q1, -Q1, 0}, '{-32'sh8000_0000, 32'sh7fff_ffff, 0}, 0);
      send_box(mk_box(Q1, -Q1, 0, 16, 16, 16, 1, 0));
      send_box(mk_box(2 * Q1, -Q1, 0, 16, 16, 16, 1, 1));
      idle_sender();
      drain();
      set_ray('{-32'sh8000_0000, 32'sh7fff_ffff, -32'sh8000_0000},
              '{Q1, -Q1, 32'sh7fff_ffff}, 31'h7fff_ffff);
      send_box(aimed_box(0));
      send_box(noise_box(0));
      send_box(aimed_box(1));
      idle_sender();
      drain();

      // long query: the box counter wraps, one hit lands early and one just past the wrap
      set_ray('{0, 0, 0}, '{0, 0, Q1}, 64 * Q1);
      for (int i = 0; i < 1030; i++) begin
         tail = (i == 1029);
         if (i == 3 || i == 1026)
            send_box(mk_box(0, 0, 8 * Q1, Q1, Q1, Q1, 1, tail));
         else
            send_box(mk_box(0, 0, 2 * Q1, Q1, Q1, Q1, 0, tail));
      end
      idle_sender();
      drain();

      // random part: one ray per phase, pacing rotates through four modes
      sent = 0;
      for (int ph = 0; sent < 180; ph++) begin
         case (ph % 4)
            0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin sender_idle_pct = 74; recv_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  recv_stall_pct = 74; end
            default: begin sender_idle_pct = 34; recv_stall_pct = 34; end
         endcase
         for (int a = 0; a < 3; a++) begin
            o[a] = ($urandom_range(0, 9) == 0) ? longint'(signed'($urandom))
                                               : longint'($urandom_range(0, 16 * Q1)) - 8 * Q1;
            d[a] = rand_dir();
         end
         if (ph % 5 == 4) d = '{-32'sh8000_0000, 0, 32'sh7fff_ffff};
         set_ray(o, d, (ph % 7 == 3) ? 31'h7fff_ffff :
                       (ph % 7 == 5) ? 0 : $urandom_range(Q1, 32 * Q1));
         // hold the receiver off once while boxes keep coming, so the block backs up
         if (ph == 2) hold_asked++;
         for (int k = 0; k < 24; ) begin
            qlen = $urandom_range(1, 8);
            for (int j = 0; j < qlen; j++) begin
               tail = (j == qlen - 1);
               send_box(($urandom_range(0, 9) < 8) ? aimed_box(tail) : noise_box(tail));
               k++;
               sent++;
            end
         end
         // pause until every report is back before touching the ray
         idle_sender();
         drain();
      end

      if (fail_count == 0 && reports_due == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
